// ===== design/peh_pkg.sv =====
// ---------------------------------------------------------------------------
// peh_pkg
// Shared types and constants of the peri-event histogram core.
// ---------------------------------------------------------------------------
package peh_pkg;

    localparam int STAMP_W  = 63;
    localparam int UNIT_W   = 4;
    localparam int BIN_W    = 8;
    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 20;
    localparam int TRIAL_W  = 16;
    localparam int BINNED_W = 11;
    localparam int MS_W     = 10;
    localparam int RATE_W   = 17;
    localparam int CFG_IDX_W = 2;

    // Offset arithmetic: magnitudes below the sample rate, scaled by 1000.
    localparam int MAG_W    = RATE_W;
    localparam int SCALED_W = 27;
    localparam int PROD_W   = 27;
    localparam int OFFSET_W = 30;
    localparam int REM_W    = 29;
    localparam int QUOT_W   = 11;
    localparam int DIVS_W   = PROD_W + QUOT_W - 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TRIAL_W-1:0] TRIAL_MAX = '1;
    localparam logic [MS_W-1:0]    OFFSET_LIMIT_MS = 10'd1000;

    localparam logic [MODE_W-1:0] MODE_SPIKE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRIGGER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PRE_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SPIKE,
        OP_TRIGGER,
        OP_CLOSE,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [STAMP_W-1:0] stamp;
        logic [UNIT_W-1:0]  unit;
        logic [BIN_W-1:0]   bin;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic sweeping;
    } ctl_t;

endpackage

// ===== design/peh_front.sv =====
// ---------------------------------------------------------------------------
// peh_front
// Accepts input items, decodes them into commands and holds them in a
// two-entry queue for the execution engine.
// ---------------------------------------------------------------------------
module peh_front #(
    parameter int MAX_UNITS = 16,
    parameter int MAX_BINS  = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [peh_pkg::MODE_W-1:0]    mode,
    input  logic [peh_pkg::STAMP_W-1:0]   stamp,
    input  logic [peh_pkg::UNIT_W-1:0]    unit_id,
    input  logic [peh_pkg::BIN_W-1:0]     bin_index,
    input  peh_pkg::ctl_t                 ctl,
    output logic                          cmd_valid,
    output peh_pkg::cmd_t                 cmd
);

    peh_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          accept;
    logic          pop;
    logic          unit_ok;
    logic          bin_ok;
    peh_pkg::cmd_t decoded;

    assign in_ready  = !ctl.sweeping && (fill_reg != 2'd2);
    assign accept    = in_valid && in_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = ctl.pop && cmd_valid;
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        unit_ok = 32'(unit_id) < MAX_UNITS;
        bin_ok  = 32'(bin_index) < MAX_BINS;
        decoded.stamp = stamp;
        decoded.unit  = unit_id;
        decoded.bin   = bin_index;
        case (mode)
            peh_pkg::MODE_SPIKE:   decoded.op = unit_ok ? peh_pkg::OP_SPIKE : peh_pkg::OP_NOP;
            peh_pkg::MODE_TRIGGER: decoded.op = peh_pkg::OP_TRIGGER;
            peh_pkg::MODE_CLOSE:   decoded.op = peh_pkg::OP_CLOSE;
            peh_pkg::MODE_READ:
                decoded.op = (unit_ok && bin_ok) ? peh_pkg::OP_READ : peh_pkg::OP_NOP;
            peh_pkg::MODE_CLEAR:   decoded.op = peh_pkg::OP_CLEAR;
            default:               decoded.op = peh_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({accept, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== design/peh_back.sv =====
// ---------------------------------------------------------------------------
// peh_back
// Execution engine: spike history ring, histogram memory, trial window,
// the window-close walk with its iterative bin divider, and the result
// register.
// ---------------------------------------------------------------------------
module peh_back #(
    parameter int HISTORY_DEPTH = 1024,
    parameter int MAX_UNITS     = 16,
    parameter int MAX_BINS      = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [peh_pkg::MS_W-1:0]       pre_window_ms,
    input  logic [peh_pkg::MS_W-1:0]       post_window_ms,
    input  logic [peh_pkg::MS_W-1:0]       bin_width_ms,
    input  logic [peh_pkg::RATE_W-1:0]     sample_rate_hz,
    input  logic                           cmd_valid,
    input  peh_pkg::cmd_t                  cmd,
    output peh_pkg::ctl_t                  ctl,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [peh_pkg::COUNT_W-1:0]    bin_count,
    output logic [peh_pkg::COUNT_W-1:0]    unit_max_count,
    output logic [peh_pkg::TRIAL_W-1:0]    trials,
    output logic [peh_pkg::BINNED_W-1:0]   spikes_binned,
    output logic                           accepted
);

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int FW     = $clog2(HISTORY_DEPTH + 1);
    localparam int NB     = MAX_UNITS * MAX_BINS;
    localparam int BA     = $clog2(NB);
    localparam int UW     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int RING_W = peh_pkg::UNIT_W + peh_pkg::STAMP_W;

    typedef enum logic [12:0] {
        S_CLR       = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_SETUP     = 13'b0000000000100,
        S_RING_RD   = 13'b0000000001000,
        S_EVAL      = 13'b0000000010000,
        S_SCALE     = 13'b0000000100000,
        S_OFFSET    = 13'b0000001000000,
        S_DIV       = 13'b0000010000000,
        S_LOOKUP    = 13'b0000100000000,
        S_UPDATE    = 13'b0001000000000,
        S_FINISH    = 13'b0010000000000,
        S_READ_WAIT = 13'b0100000000000,
        S_RESULT    = 13'b1000000000000
    } state_t;

    // Storage
    logic [RING_W-1:0]            ring_mem [HISTORY_DEPTH];
    logic [peh_pkg::COUNT_W-1:0]  bin_mem  [NB];
    logic [peh_pkg::COUNT_W-1:0]  max_reg  [MAX_UNITS];

    logic                         ring_we;
    logic                         ring_re;
    logic [AW-1:0]                ring_waddr;
    logic [RING_W-1:0]            ring_wdata;
    logic [RING_W-1:0]            ring_rd_reg;
    logic                         bin_we;
    logic                         bin_re;
    logic [BA-1:0]                bin_waddr;
    logic [BA-1:0]                bin_raddr;
    logic [peh_pkg::COUNT_W-1:0]  bin_wdata;
    logic [peh_pkg::COUNT_W-1:0]  bin_rd_reg;
    logic                         max_init;
    logic                         max_we;
    logic [UW-1:0]                max_sel;
    logic [peh_pkg::COUNT_W-1:0]  max_wdata;

    // Control state
    state_t                       state_reg, state_next;
    peh_pkg::cmd_t                cur_reg, cur_next;
    logic [AW-1:0]                head_reg, head_next;
    logic [FW-1:0]                fill_reg, fill_next;
    logic [FW-1:0]                walk_reg, walk_next;
    logic                         open_reg, open_next;
    logic [peh_pkg::STAMP_W-1:0]  trig_reg, trig_next;
    logic [peh_pkg::TRIAL_W-1:0]  trial_reg, trial_next;
    logic [BA-1:0]                clr_reg, clr_next;
    logic                         clr_cmd_reg, clr_cmd_next;
    logic [3:0]                   bit_reg, bit_next;

    // Walk datapath
    logic [peh_pkg::PROD_W-1:0]   pre_s_reg, pre_s_next;
    logic [peh_pkg::PROD_W-1:0]   post_s_reg, post_s_next;
    logic [peh_pkg::PROD_W-1:0]   step_reg, step_next;
    logic [peh_pkg::MAG_W-1:0]    mag_reg, mag_next;
    logic                         far_reg, far_next;
    logic                         neg_reg, neg_next;
    logic [peh_pkg::SCALED_W-1:0] xmag_reg, xmag_next;
    logic [peh_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [peh_pkg::QUOT_W-1:0]   quot_reg, quot_next;
    logic [BA-1:0]                cell_reg, cell_next;
    logic [peh_pkg::BINNED_W-1:0] binned_reg, binned_next;

    // Result being built and output register
    logic [peh_pkg::COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [peh_pkg::COUNT_W-1:0]  res_max_reg, res_max_next;
    logic                         res_acc_reg, res_acc_next;
    logic                         out_valid_reg, out_valid_next;
    logic [peh_pkg::COUNT_W-1:0]  out_count_reg;
    logic [peh_pkg::COUNT_W-1:0]  out_max_reg;
    logic [peh_pkg::TRIAL_W-1:0]  out_trials_reg;
    logic [peh_pkg::BINNED_W-1:0] out_binned_reg;
    logic                         out_acc_reg;
    logic                         out_load;

    // Combinational helpers
    logic [peh_pkg::RATE_W-1:0]   rate_eff;
    logic [peh_pkg::MS_W-1:0]     bw_eff;
    logic [peh_pkg::STAMP_W-1:0]  spike_stamp;
    logic [peh_pkg::UNIT_W-1:0]   spike_unit;
    logic [31:0]                  spike_unit_ext;
    logic [31:0]                  cur_unit_ext;
    logic [31:0]                  addr_wide;
    logic [peh_pkg::STAMP_W-1:0]  diff_fwd;
    logic [peh_pkg::STAMP_W-1:0]  diff_bwd;
    logic                         stamp_ge;
    logic signed [peh_pkg::OFFSET_W-1:0] x_signed;
    logic signed [peh_pkg::OFFSET_W-1:0] y_signed;
    logic signed [peh_pkg::OFFSET_W-1:0] post_signed;
    logic signed [peh_pkg::OFFSET_W-1:0] pre_signed;
    logic [peh_pkg::DIVS_W-1:0]   div_shifted;
    logic [peh_pkg::DIVS_W-1:0]   div_rem;
    logic [peh_pkg::DIVS_W-1:0]   div_diff;
    logic [peh_pkg::COUNT_W-1:0]  inc_count;
    logic [FW-1:0]                walk_inc;
    logic                         walk_last;

    assign ctl.pop      = (state_reg == S_IDLE) && cmd_valid;
    assign ctl.sweeping = (state_reg == S_CLR);

    assign out_valid      = out_valid_reg;
    assign bin_count      = out_count_reg;
    assign unit_max_count = out_max_reg;
    assign trials         = out_trials_reg;
    assign spikes_binned  = out_binned_reg;
    assign accepted       = out_acc_reg;

    always_comb
    begin
        rate_eff = (sample_rate_hz == '0) ? peh_pkg::RATE_W'(1) : sample_rate_hz;
        bw_eff   = (bin_width_ms == '0) ? peh_pkg::MS_W'(1) : bin_width_ms;

        spike_stamp    = ring_rd_reg[peh_pkg::STAMP_W-1:0];
        spike_unit     = ring_rd_reg[RING_W-1:peh_pkg::STAMP_W];
        spike_unit_ext = 32'(spike_unit);
        cur_unit_ext   = 32'(cur_reg.unit);

        diff_fwd = spike_stamp - trig_reg;
        diff_bwd = trig_reg - spike_stamp;
        stamp_ge = (spike_stamp >= trig_reg);

        post_signed = $signed({3'b000, post_s_reg});
        pre_signed  = $signed({3'b000, pre_s_reg});
        x_signed    = neg_reg ? -$signed({3'b000, xmag_reg}) : $signed({3'b000, xmag_reg});
        y_signed    = x_signed + pre_signed;

        div_shifted = peh_pkg::DIVS_W'(step_reg) << bit_reg;
        div_rem     = peh_pkg::DIVS_W'(rem_reg);
        div_diff    = div_rem - div_shifted;

        inc_count = (bin_rd_reg == peh_pkg::COUNT_MAX) ? bin_rd_reg
                                                        : bin_rd_reg + peh_pkg::COUNT_W'(1);
        walk_inc  = walk_reg + FW'(1);
        walk_last = (walk_inc == fill_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        walk_next      = walk_reg;
        open_next      = open_reg;
        trig_next      = trig_reg;
        trial_next     = trial_reg;
        clr_next       = clr_reg;
        clr_cmd_next   = clr_cmd_reg;
        bit_next       = bit_reg;
        pre_s_next     = pre_s_reg;
        post_s_next    = post_s_reg;
        step_next      = step_reg;
        mag_next       = mag_reg;
        far_next       = far_reg;
        neg_next       = neg_reg;
        xmag_next      = xmag_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cell_next      = cell_reg;
        binned_next    = binned_reg;
        res_count_next = res_count_reg;
        res_max_next   = res_max_reg;
        res_acc_next   = res_acc_reg;

        addr_wide  = '0;
        ring_we    = 1'b0;
        ring_re    = 1'b0;
        ring_waddr = head_reg;
        ring_wdata = {cmd.unit, cmd.stamp};
        bin_we     = 1'b0;
        bin_re     = 1'b0;
        bin_waddr  = cell_reg;
        bin_raddr  = cell_reg;
        bin_wdata  = inc_count;
        max_init   = 1'b0;
        max_we     = 1'b0;
        max_sel    = spike_unit_ext[UW-1:0];
        max_wdata  = inc_count;
        out_load   = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                bin_we    = 1'b1;
                bin_waddr = clr_reg;
                bin_wdata = '0;
                clr_next  = clr_reg + BA'(1);
                if (clr_reg == BA'(NB - 1))
                begin
                    clr_next   = '0;
                    state_next = clr_cmd_reg ? S_RESULT : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next       = cmd;
                    res_count_next = '0;
                    res_max_next   = peh_pkg::COUNT_W'(1);
                    res_acc_next   = 1'b0;
                    binned_next    = '0;
                    state_next     = S_RESULT;
                    case (cmd.op)
                        peh_pkg::OP_SPIKE:
                        begin
                            ring_we      = 1'b1;
                            head_next    = (head_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                                : head_reg + AW'(1);
                            if (fill_reg != FW'(HISTORY_DEPTH))
                            begin
                                fill_next = fill_reg + FW'(1);
                            end
                            res_acc_next = 1'b1;
                        end
                        peh_pkg::OP_TRIGGER:
                        begin
                            if (!open_reg)
                            begin
                                trig_next    = cmd.stamp;
                                open_next    = 1'b1;
                                res_acc_next = 1'b1;
                            end
                        end
                        peh_pkg::OP_CLOSE:
                        begin
                            if (open_reg)
                            begin
                                walk_next  = '0;
                                state_next = S_SETUP;
                            end
                        end
                        peh_pkg::OP_READ:
                        begin
                            addr_wide  = 32'(cmd.unit) * 32'(MAX_BINS) + 32'(cmd.bin);
                            bin_re     = 1'b1;
                            bin_raddr  = addr_wide[BA-1:0];
                            state_next = S_READ_WAIT;
                        end
                        peh_pkg::OP_CLEAR:
                        begin
                            head_next    = '0;
                            fill_next    = '0;
                            open_next    = 1'b0;
                            trig_next    = '0;
                            trial_next   = '0;
                            max_init     = 1'b1;
                            clr_next     = '0;
                            clr_cmd_next = 1'b1;
                            res_acc_next = 1'b1;
                            state_next   = S_CLR;
                        end
                        default:
                        begin
                            res_acc_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SETUP:
            begin
                pre_s_next  = peh_pkg::PROD_W'(pre_window_ms) * peh_pkg::PROD_W'(rate_eff);
                post_s_next = peh_pkg::PROD_W'(post_window_ms) * peh_pkg::PROD_W'(rate_eff);
                step_next   = peh_pkg::PROD_W'(bw_eff) * peh_pkg::PROD_W'(rate_eff);
                state_next  = (fill_reg == '0) ? S_FINISH : S_RING_RD;
            end

            S_RING_RD:
            begin
                ring_re    = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                // Distance to the trigger as magnitude and sign.
                neg_next   = !stamp_ge;
                far_next   = stamp_ge ? (diff_fwd[peh_pkg::STAMP_W-1:peh_pkg::MAG_W] != '0)
                                      : (diff_bwd[peh_pkg::STAMP_W-1:peh_pkg::MAG_W] != '0);
                mag_next   = stamp_ge ? diff_fwd[peh_pkg::MAG_W-1:0]
                                      : diff_bwd[peh_pkg::MAG_W-1:0];
                state_next = S_SCALE;
            end

            S_SCALE:
            begin
                xmag_next = peh_pkg::SCALED_W'(mag_reg)
                          * peh_pkg::SCALED_W'(peh_pkg::OFFSET_LIMIT_MS);
                if (far_reg || (mag_reg >= rate_eff) || (spike_unit_ext >= 32'(MAX_UNITS)))
                begin
                    walk_next  = walk_inc;
                    state_next = walk_last ? S_FINISH : S_RING_RD;
                end
                else
                begin
                    state_next = S_OFFSET;
                end
            end

            S_OFFSET:
            begin
                if ((x_signed >= post_signed) || (y_signed <= 0))
                begin
                    walk_next  = walk_inc;
                    state_next = walk_last ? S_FINISH : S_RING_RD;
                end
                else
                begin
                    rem_next   = y_signed[peh_pkg::REM_W-1:0];
                    quot_next  = '0;
                    bit_next   = 4'(peh_pkg::QUOT_W - 1);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (div_rem >= div_shifted)
                begin
                    rem_next           = div_diff[peh_pkg::REM_W-1:0];
                    quot_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                // A spike exactly on an edge, or past the last bin, is skipped.
                if ((rem_reg == '0) || (32'(quot_reg) >= 32'(MAX_BINS)))
                begin
                    walk_next  = walk_inc;
                    state_next = walk_last ? S_FINISH : S_RING_RD;
                end
                else
                begin
                    addr_wide  = spike_unit_ext * 32'(MAX_BINS) + 32'(quot_reg);
                    bin_re     = 1'b1;
                    bin_raddr  = addr_wide[BA-1:0];
                    cell_next  = addr_wide[BA-1:0];
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                bin_we      = 1'b1;
                bin_waddr   = cell_reg;
                bin_wdata   = inc_count;
                max_sel     = spike_unit_ext[UW-1:0];
                max_wdata   = inc_count;
                max_we      = (inc_count > max_reg[spike_unit_ext[UW-1:0]]);
                binned_next = binned_reg + peh_pkg::BINNED_W'(1);
                walk_next   = walk_inc;
                state_next  = walk_last ? S_FINISH : S_RING_RD;
            end

            S_FINISH:
            begin
                if (trial_reg != peh_pkg::TRIAL_MAX)
                begin
                    trial_next = trial_reg + peh_pkg::TRIAL_W'(1);
                end
                open_next    = 1'b0;
                res_acc_next = 1'b1;
                state_next   = S_RESULT;
            end

            S_READ_WAIT:
            begin
                res_count_next = bin_rd_reg;
                res_max_next   = max_reg[cur_unit_ext[UW-1:0]];
                res_acc_next   = 1'b1;
                state_next     = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load     = 1'b1;
                    clr_cmd_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // History ring
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[walk_reg[AW-1:0]];
        end
    end

    // Histogram memory
    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        if (bin_re)
        begin
            bin_rd_reg <= bin_mem[bin_raddr];
        end
    end

    // Per-unit maxima
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_UNITS; i++)
            begin
                max_reg[i] <= peh_pkg::COUNT_W'(1);
            end
        end
        else if (max_init)
        begin
            for (int i = 0; i < MAX_UNITS; i++)
            begin
                max_reg[i] <= peh_pkg::COUNT_W'(1);
            end
        end
        else if (max_we)
        begin
            max_reg[max_sel] <= max_wdata;
        end
    end

    // Datapath and result payload
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        pre_s_reg     <= pre_s_next;
        post_s_reg    <= post_s_next;
        step_reg      <= step_next;
        mag_reg       <= mag_next;
        far_reg       <= far_next;
        neg_reg       <= neg_next;
        xmag_reg      <= xmag_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        cell_reg      <= cell_next;
        bit_reg       <= bit_next;
        res_count_reg <= res_count_next;
        res_max_reg   <= res_max_next;
        res_acc_reg   <= res_acc_next;
        if (out_load)
        begin
            out_count_reg  <= res_count_reg;
            out_max_reg    <= res_max_reg;
            out_trials_reg <= trial_reg;
            out_binned_reg <= binned_reg;
            out_acc_reg    <= res_acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            head_reg      <= '0;
            fill_reg      <= '0;
            walk_reg      <= '0;
            open_reg      <= 1'b0;
            trig_reg      <= '0;
            trial_reg     <= '0;
            clr_reg       <= '0;
            clr_cmd_reg   <= 1'b0;
            binned_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            walk_reg      <= walk_next;
            open_reg      <= open_next;
            trig_reg      <= trig_next;
            trial_reg     <= trial_next;
            clr_reg       <= clr_next;
            clr_cmd_reg   <= clr_cmd_next;
            binned_reg    <= binned_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/peri_event_histogram_core.sv =====
// ---------------------------------------------------------------------------
// peri_event_histogram_core
// Per-unit peri-event time histogram built from a spike history ring.
// ---------------------------------------------------------------------------
// Items enter on the in_valid/in_ready channel; every item gives exactly one
// result on the out_valid/out_ready channel, in order. Settings are written
// on cfg_write/cfg_index/cfg_data; the user must write them only while the
// block is idle, and the block itself has no check for this. A bin read
// passes through an extra wait state on its way from transfer to result.
// A window close walks every stored spike through a shared offset unit and
// an 11-step bin divider; spikes outside the window leave the walk earlier.
// A clear, and reset, sweep the histogram memory one entry per cycle:
// MAX_UNITS * MAX_BINS entries (4096 by default), during which in_ready is
// low; after a clear its result follows the sweep.
// A two-entry command queue sits between the input and the engine, so new
// items are taken while a result waits. If the receiver holds out_ready low
// the result stays in the output register and the engine stops after
// finishing the next item; the queue then fills and in_ready drops.
// ---------------------------------------------------------------------------
module peri_event_histogram_core #(
    parameter int HISTORY_DEPTH = 1024,
    parameter int MAX_UNITS     = 16,
    parameter int MAX_BINS      = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [peh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [peh_pkg::RATE_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [peh_pkg::MODE_W-1:0]        mode,
    input  logic [peh_pkg::STAMP_W-1:0]       stamp,
    input  logic [peh_pkg::UNIT_W-1:0]        unit_id,
    input  logic [peh_pkg::BIN_W-1:0]         bin_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [peh_pkg::COUNT_W-1:0]       bin_count,
    output logic [peh_pkg::COUNT_W-1:0]       unit_max_count,
    output logic [peh_pkg::TRIAL_W-1:0]       trials,
    output logic [peh_pkg::BINNED_W-1:0]      spikes_binned,
    output logic                              accepted
);

    logic [peh_pkg::MS_W-1:0]   pre_window_reg;
    logic [peh_pkg::MS_W-1:0]   post_window_reg;
    logic [peh_pkg::MS_W-1:0]   bin_width_reg;
    logic [peh_pkg::RATE_W-1:0] sample_rate_reg;

    peh_pkg::ctl_t ctl;
    peh_pkg::cmd_t cmd;
    logic          cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_window_reg  <= '0;
            post_window_reg <= '0;
            bin_width_reg   <= peh_pkg::MS_W'(10);
            sample_rate_reg <= peh_pkg::RATE_W'(30000);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                peh_pkg::CFG_PRE_WINDOW:  pre_window_reg  <= cfg_data[peh_pkg::MS_W-1:0];
                peh_pkg::CFG_POST_WINDOW: post_window_reg <= cfg_data[peh_pkg::MS_W-1:0];
                peh_pkg::CFG_BIN_WIDTH:   bin_width_reg   <= cfg_data[peh_pkg::MS_W-1:0];
                peh_pkg::CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                default:                  sample_rate_reg <= sample_rate_reg;
            endcase
        end
    end

    peh_front #(
        .MAX_UNITS (MAX_UNITS),
        .MAX_BINS  (MAX_BINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .stamp     (stamp),
        .unit_id   (unit_id),
        .bin_index (bin_index),
        .ctl       (ctl),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    peh_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_UNITS     (MAX_UNITS),
        .MAX_BINS      (MAX_BINS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pre_window_ms  (pre_window_reg),
        .post_window_ms (post_window_reg),
        .bin_width_ms   (bin_width_reg),
        .sample_rate_hz (sample_rate_reg),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .ctl            (ctl),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bin_count      (bin_count),
        .unit_max_count (unit_max_count),
        .trials         (trials),
        .spikes_binned  (spikes_binned),
        .accepted       (accepted)
    );

endmodule

// ===== dv/peri_event_histogram_core_test.sv =====
// ---------------------------------------------------------------------------
// peri_event_histogram_core_test
// Self-checking bench for the peri-event histogram core. Trials are built
// around random trigger times, with spikes placed on, beside and between bin
// edges. A scoreboard class keeps its own copy of the ring, the histograms
// and the settings, and predicts every result, which it then checks in
// order. Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module peri_event_histogram_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH   = 1024;
    localparam int UNIT_COUNT   = 16;
    localparam int BIN_COUNT    = 256;
    localparam int ITEM_TARGET  = 1250;
    localparam int PHASE_ITEMS  = (ITEM_TARGET - RING_DEPTH - 120) / 6;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [peh_pkg::MODE_W-1:0] MODE_BAD_FIRST = 3'd5;
    localparam logic [peh_pkg::MODE_W-1:0] MODE_BAD_LAST  = 3'd7;

    typedef struct {
        logic [peh_pkg::COUNT_W-1:0]  count;
        logic [peh_pkg::COUNT_W-1:0]  max_count;
        logic [peh_pkg::TRIAL_W-1:0]  trials;
        logic [peh_pkg::BINNED_W-1:0] binned;
        logic                         acc;
    } histo_result_t;

    class histo_scoreboard;
        logic [peh_pkg::STAMP_W-1:0] ring_stamp [RING_DEPTH];
        logic [peh_pkg::UNIT_W-1:0]  ring_unit [RING_DEPTH];
        int                          head;
        int                          fill;
        logic [peh_pkg::COUNT_W-1:0] counts [UNIT_COUNT*BIN_COUNT];
        logic [peh_pkg::COUNT_W-1:0] peaks [UNIT_COUNT];
        logic [peh_pkg::STAMP_W-1:0] trig_stamp;
        logic                        open;
        logic [peh_pkg::TRIAL_W-1:0] trial_total;
        logic [peh_pkg::MS_W-1:0]    pre_ms, post_ms, width_ms;
        logic [peh_pkg::RATE_W-1:0]  rate_hz;
        histo_result_t               expected_q [$];
        int                          errors;
        int                          checked;
        int                          closes;
        int                          binned_total;

        function new();
            pre_ms = 0;
            post_ms = 0;
            width_ms = 10;
            rate_hz = 30000;
            errors = 0;
            checked = 0;
            closes = 0;
            binned_total = 0;
            wipe();
        endfunction

        function void wipe();
            head = 0;
            fill = 0;
            foreach (counts[i]) counts[i] = '0;
            foreach (peaks[i]) peaks[i] = 1;
            trig_stamp = '0;
            open = 0;
            trial_total = '0;
        endfunction

        function void write_cfg(logic [peh_pkg::CFG_IDX_W-1:0] idx,
                                logic [peh_pkg::RATE_W-1:0] data);
            case (idx)
                peh_pkg::CFG_PRE_WINDOW:  pre_ms = data[peh_pkg::MS_W-1:0];
                peh_pkg::CFG_POST_WINDOW: post_ms = data[peh_pkg::MS_W-1:0];
                peh_pkg::CFG_BIN_WIDTH:   width_ms = data[peh_pkg::MS_W-1:0];
                default:                  rate_hz = data;
            endcase
        endfunction

        // Walks the ring; offsets are compared exactly as d*1000 against edge*rate.
        function int bin_trial();
            longint rate, bw, pre_s, post_s, step, x, y, j;
            logic [peh_pkg::STAMP_W-1:0] mag;
            logic neg;
            int n, slot;
            rate = (rate_hz == 0) ? 1 : longint'(rate_hz);
            bw = (width_ms == 0) ? 1 : longint'(width_ms);
            pre_s = longint'(pre_ms) * rate;
            post_s = longint'(post_ms) * rate;
            step = bw * rate;
            n = 0;
            for (int i = 0; i < fill; i++) begin
                neg = ring_stamp[i] < trig_stamp;
                mag = neg ? trig_stamp - ring_stamp[i] : ring_stamp[i] - trig_stamp;
                if (mag >= peh_pkg::STAMP_W'(rate)) continue;
                x = longint'(mag) * 1000;
                if (neg) x = -x;
                if (x >= post_s) continue;
                y = x + pre_s;
                if (y <= 0 || y % step == 0) continue;
                j = y / step;
                if (j >= BIN_COUNT) continue;
                slot = int'(ring_unit[i]) * BIN_COUNT + int'(j);
                if (counts[slot] != peh_pkg::COUNT_MAX) counts[slot]++;
                if (counts[slot] > peaks[ring_unit[i]]) peaks[ring_unit[i]] = counts[slot];
                n++;
            end
            if (trial_total != peh_pkg::TRIAL_MAX) trial_total++;
            open = 0;
            return n;
        endfunction

        function void note(logic [peh_pkg::MODE_W-1:0] m, logic [peh_pkg::STAMP_W-1:0] st,
                           logic [peh_pkg::UNIT_W-1:0] u, logic [peh_pkg::BIN_W-1:0] b);
            histo_result_t r;
            int n;
            r.count = '0;
            r.max_count = 1;
            r.binned = '0;
            r.acc = 0;
            case (m)
                peh_pkg::MODE_SPIKE: begin
                    ring_stamp[head] = st;
                    ring_unit[head] = u;
                    head = (head + 1) % RING_DEPTH;
                    if (fill < RING_DEPTH) fill++;
                    r.acc = 1;
                end
                peh_pkg::MODE_TRIGGER: if (!open) begin
                    trig_stamp = st;
                    open = 1;
                    r.acc = 1;
                end
                peh_pkg::MODE_CLOSE: if (open) begin
                    n = bin_trial();
                    closes++;
                    binned_total += n;
                    r.binned = peh_pkg::BINNED_W'(n);
                    r.acc = 1;
                end
                peh_pkg::MODE_READ: begin
                    r.count = counts[int'(u) * BIN_COUNT + int'(b)];
                    r.max_count = peaks[u];
                    r.acc = 1;
                end
                peh_pkg::MODE_CLEAR: begin
                    wipe();
                    r.acc = 1;
                end
                default: ;
            endcase
            r.trials = trial_total;
            expected_q.push_back(r);
        endfunction

        function void check(histo_result_t got);
            histo_result_t e;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.count !== e.count) begin
                $error("bin_count expected %0d got %0d", e.count, got.count);
                errors++;
            end
            if (got.max_count !== e.max_count) begin
                $error("unit_max_count expected %0d got %0d", e.max_count, got.max_count);
                errors++;
            end
            if (got.trials !== e.trials) begin
                $error("trials expected %0d got %0d", e.trials, got.trials);
                errors++;
            end
            if (got.binned !== e.binned) begin
                $error("spikes_binned expected %0d got %0d", e.binned, got.binned);
                errors++;
            end
            if (got.acc !== e.acc) begin
                $error("accepted expected %0d got %0d", e.acc, got.acc);
                errors++;
            end
        endfunction
    endclass

    logic                          clk = 0;
    logic                          rst_n = 0;
    logic                          cfg_write = 0;
    logic [peh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [peh_pkg::RATE_W-1:0]    cfg_data = '0;
    logic                          in_valid = 0;
    logic                          in_ready;
    logic [peh_pkg::MODE_W-1:0]    mode = '0;
    logic [peh_pkg::STAMP_W-1:0]   stamp = '0;
    logic [peh_pkg::UNIT_W-1:0]    unit_id = '0;
    logic [peh_pkg::BIN_W-1:0]     bin_index = '0;
    logic                          out_valid;
    logic                          out_ready = 0;
    logic [peh_pkg::COUNT_W-1:0]   bin_count;
    logic [peh_pkg::COUNT_W-1:0]   unit_max_count;
    logic [peh_pkg::TRIAL_W-1:0]   trials;
    logic [peh_pkg::BINNED_W-1:0]  spikes_binned;
    logic                          accepted;

    histo_scoreboard sb = new();
    int  items_sent = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  calm = 0;

    peri_event_histogram_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .stamp(stamp), .unit_id(unit_id), .bin_index(bin_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .bin_count(bin_count), .unit_max_count(unit_max_count), .trials(trials),
        .spikes_binned(spikes_binned), .accepted(accepted)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** peri_event_histogram_core: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Result side: check every transfer, then decide the next stall.
    always @(posedge clk) begin
        histo_result_t got;
        if (out_valid && out_ready) begin
            got.count = bin_count;
            got.max_count = unit_max_count;
            got.trials = trials;
            got.binned = spikes_binned;
            got.acc = accepted;
            sb.check(got);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 0;
        end else begin
            out_ready <= 1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_item(logic [peh_pkg::MODE_W-1:0] m, logic [peh_pkg::STAMP_W-1:0] st,
                             logic [peh_pkg::UNIT_W-1:0] u, logic [peh_pkg::BIN_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        mode <= m;
        stamp <= st;
        unit_id <= u;
        bin_index <= b;
        do @(posedge clk); while (!in_ready);
        sb.note(m, st, u, b);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [peh_pkg::CFG_IDX_W-1:0] idx, int value);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= peh_pkg::RATE_W'(value);
        sb.write_cfg(idx, peh_pkg::RATE_W'(value));
        @(posedge clk);
    endtask

    task automatic configure(int pre, int post, int bw, int rate);
        wait_idle();
        repeat (8) @(posedge clk);
        write_reg(peh_pkg::CFG_PRE_WINDOW, pre);
        write_reg(peh_pkg::CFG_POST_WINDOW, post);
        write_reg(peh_pkg::CFG_BIN_WIDTH, bw);
        write_reg(peh_pkg::CFG_SAMPLE_RATE, rate);
        cfg_write <= 0;
        @(posedge clk);
    endtask

    function automatic logic [peh_pkg::STAMP_W-1:0] random_stamp();
        return {$urandom(), $urandom()};
    endfunction

    // Offsets in samples, biased toward the window limits and the bin edges.
    function automatic longint pick_offset();
        longint rate, bw, e;
        int nbins;
        rate = (sb.rate_hz == 0) ? 1 : longint'(sb.rate_hz);
        bw = (sb.width_ms == 0) ? 1 : longint'(sb.width_ms);
        nbins = int'((longint'(sb.pre_ms) + sb.post_ms) / bw) + 1;
        case ($urandom_range(0, 5))
            0, 1: return longint'($urandom_range(0, 2 * rate)) - rate;
            2: begin
                e = -longint'(sb.pre_ms) + bw * $urandom_range(0, nbins);
                return e * rate / 1000;
            end
            3: begin
                e = -longint'(sb.pre_ms) + bw * $urandom_range(0, nbins);
                return e * rate / 1000 + ($urandom_range(0, 1) ? 1 : -1);
            end
            4: return $urandom_range(0, 1) ? rate - 1 : -(rate - 1);
            default: return $urandom_range(0, 1) ? rate : -rate;
        endcase
    endfunction

    function automatic logic [peh_pkg::BIN_W-1:0] pick_bin();
        int bw, top;
        bw = (sb.width_ms == 0) ? 1 : int'(sb.width_ms);
        top = (int'(sb.pre_ms) + int'(sb.post_ms)) / bw;
        if (top > 255) top = 255;
        if ($urandom_range(0, 9) == 0) return peh_pkg::BIN_W'($urandom_range(0, 255));
        return peh_pkg::BIN_W'($urandom_range(0, top));
    endfunction

    task automatic spike_near(logic [peh_pkg::STAMP_W-1:0] t);
        send_item(peh_pkg::MODE_SPIKE, t + peh_pkg::STAMP_W'(pick_offset()),
                  peh_pkg::UNIT_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                             : $urandom_range(0, 2)), '0);
    endtask

    task automatic noise_item();
        logic [peh_pkg::MODE_W-1:0] m;
        m = $urandom_range(0, 9) == 0 ?
            peh_pkg::MODE_W'($urandom_range(MODE_BAD_FIRST, MODE_BAD_LAST)) :
            peh_pkg::MODE_W'($urandom_range(peh_pkg::MODE_SPIKE, peh_pkg::MODE_CLEAR));
        // Keep clears rare: each one costs a full sweep of the histogram memory.
        if (m == peh_pkg::MODE_CLEAR && $urandom_range(0, 3) != 0) m = peh_pkg::MODE_READ;
        send_item(m, random_stamp(), peh_pkg::UNIT_W'($urandom()), peh_pkg::BIN_W'($urandom()));
    endtask

    task automatic run_trial();
        logic [peh_pkg::STAMP_W-1:0] t;
        int n_pre, n_post, n_reads;
        case ($urandom_range(0, 5))
            0: t = peh_pkg::STAMP_W'($urandom_range(0, 200000));
            1: t = '1 - peh_pkg::STAMP_W'($urandom_range(0, 200000));
            default: t = random_stamp();
        endcase
        n_pre = $urandom_range(0, 6);
        n_post = $urandom_range(0, 8);
        n_reads = $urandom_range(1, 4);
        repeat (n_pre) spike_near(t);
        send_item(peh_pkg::MODE_TRIGGER, t, peh_pkg::UNIT_W'($urandom()),
                  peh_pkg::BIN_W'($urandom()));
        if ($urandom_range(0, 7) == 0)
            send_item(peh_pkg::MODE_TRIGGER, random_stamp(), '0, '0);
        repeat (n_post) spike_near(t);
        if ($urandom_range(0, 9) != 0)
            send_item(peh_pkg::MODE_CLOSE, random_stamp(), peh_pkg::UNIT_W'($urandom()),
                      peh_pkg::BIN_W'($urandom()));
        repeat (n_reads)
            send_item(peh_pkg::MODE_READ, random_stamp(),
                      peh_pkg::UNIT_W'($urandom_range(0, 3)), pick_bin());
        if ($urandom_range(0, 3) == 0) noise_item();
    endtask

    initial begin
        int settings [6][4];
        logic [peh_pkg::STAMP_W-1:0] t;
        int quota;
        bit drained;
        settings = '{'{100, 100, 10, 30000}, '{1000, 1000, 1000, 100000},
                     '{1000, 1000, 1, 1000}, '{0, 1000, 0, 0},
                     '{37, 59, 7, 44100}, '{250, 0, 3, 1000}};
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Reset settings: empty histograms, ignored closes and triggers.
        send_item(peh_pkg::MODE_READ, '0, '1, '1);
        send_item(peh_pkg::MODE_CLOSE, '0, '0, '0);
        send_item(MODE_BAD_FIRST, '1, '1, '1);
        send_item(MODE_BAD_LAST, '0, '0, '0);
        send_item(peh_pkg::MODE_TRIGGER, '0, '0, '0);
        send_item(peh_pkg::MODE_TRIGGER, '1, '0, '0);
        send_item(peh_pkg::MODE_SPIKE, '1, '1, '1);
        send_item(peh_pkg::MODE_SPIKE, '0, '0, '0);
        send_item(peh_pkg::MODE_CLOSE, '0, '0, '0);

        // Window of 100 ms each side, 10 ms bins, 30 samples per ms.
        configure(100, 100, 10, 30000);
        t = 63'd1000000;
        send_item(peh_pkg::MODE_SPIKE, t - 3000, 1, '0);   // exactly on the lowest edge
        send_item(peh_pkg::MODE_SPIKE, t - 2999, 1, '0);   // first bin
        send_item(peh_pkg::MODE_SPIKE, t + 2999, 1, '0);   // last bin
        send_item(peh_pkg::MODE_SPIKE, t + 3000, 1, '0);   // on the closing edge
        send_item(peh_pkg::MODE_SPIKE, t, 2, '0);          // on the edge at the trigger
        send_item(peh_pkg::MODE_SPIKE, t + 150, 2, '0);
        send_item(peh_pkg::MODE_SPIKE, t - 29999, 3, '0);  // inside one second, before the window
        send_item(peh_pkg::MODE_SPIKE, t + 30000, 3, '0);  // a full second away
        send_item(peh_pkg::MODE_TRIGGER, t, '0, '0);
        send_item(peh_pkg::MODE_CLOSE, '0, '0, '0);
        send_item(peh_pkg::MODE_READ, '0, 1, 0);
        send_item(peh_pkg::MODE_READ, '0, 1, 19);
        send_item(peh_pkg::MODE_READ, '0, 2, 10);
        send_item(peh_pkg::MODE_CLEAR, '0, '0, '0);
        send_item(peh_pkg::MODE_READ, '0, 1, 0);

        // Random trials, one phase per setting.
        for (int p = 0; p < 6; p++) begin
            configure(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
            calm = (p == 4);
            quota = items_sent + PHASE_ITEMS;
            drained = 0;
            while (items_sent < quota) begin
                run_trial();
                if (!drained && items_sent >= quota - PHASE_ITEMS / 2) begin
                    // Let the block drain completely in the middle of the phase.
                    wait_idle();
                    drained = 1;
                end
            end
            calm = 0;
        end

        // Overfill the ring so the oldest spikes are overwritten, then bin it.
        configure(500, 500, 4, 8000);
        send_item(peh_pkg::MODE_CLEAR, '0, '0, '0);
        t = random_stamp();
        repeat (RING_DEPTH + 6) spike_near(t);
        send_item(peh_pkg::MODE_TRIGGER, t, '0, '0);
        send_item(peh_pkg::MODE_CLOSE, '0, '0, '0);
        for (int i = 0; i < 12; i++)
            send_item(peh_pkg::MODE_READ, '0, peh_pkg::UNIT_W'($urandom_range(0, 2)),
                      pick_bin());
        repeat (3) run_trial();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items, checked %0d results; %0d windows closed, %0d spikes binned.",
                 items_sent, sb.checked, sb.closes, sb.binned_total);
        $display("Covered edge hits, window limits, ring overwrite, clears and seven settings.");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("** peri_event_histogram_core: PASSED **");
        else
            $display("** peri_event_histogram_core: FAILED **");
        $finish;
    end

endmodule
